// File: rtl/phr_pkg.sv
`default_nettype none

package phr_pkg;

   localparam int PAL_COUNT   = 6;
   localparam int PAL_ENTRIES = 8;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [23:0] color_type;

   // request and result payloads
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // interpolated palette color waiting for shading
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } shade_type;

   localparam logic [2:0] PAL_RAINBOW   = 3'd0;
   localparam logic [2:0] PAL_REORDERED = 3'd1;
   localparam logic [2:0] PAL_SUNNY     = 3'd2;
   localparam logic [2:0] PAL_COLD      = 3'd3;
   localparam logic [2:0] PAL_GREEN     = 3'd4;
   localparam logic [2:0] PAL_FLAG      = 3'd5;

   localparam color_type PAL_ROM [PAL_COUNT][PAL_ENTRIES] = '{
      '{24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h00FF00,
        24'h00FFFF, 24'h0000FF, 24'h8000FF, 24'hFF0000},
      '{24'h00FFFF, 24'h8000FF, 24'h0000FF, 24'hFFFF00,
        24'h00FF00, 24'hFF8000, 24'hFF0000, 24'h00FFFF},
      '{24'hFFFF00, 24'hFF8000, 24'hFF0000, 24'hFFFF00,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'h00FFFF, 24'h0080FF, 24'h0000FF, 24'h00FFFF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'h80FF00, 24'hBFFF00, 24'hFFFF00, 24'h80FF00,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000}
   };

endpackage

`default_nettype wire

// File: rtl/palette_hsv_to_rgb.sv
// Palette based HSV to RGB conversion.
// Requests enter on req_push/req_full with req_data {hue, saturation, brightness};
// a request is taken on a clock edge with req_push high and req_full low.
// Results leave on rsp_empty/rsp_pop: rsp_data {red, green, blue} shows the
// oldest result while rsp_empty is low and is taken on an edge with rsp_pop high.
// The palette code is written on csr_valid/csr_ready/csr_data (csr_ready is always
// high); codes 6 and 7 fall back to the rainbow palette. Write it only while idle.
// Throughput: one request per cycle while rsp_pop keeps up, set by the interpolation
// stage and the three-stage shading pipeline, each taking an item every unstalled cycle.
// A request passes the front register, the queue, then two multiplier stages with
// a divide by 255 after each, and the result register.
// When rsp_pop stays low the shading pipeline fills, then the queue of
// QUEUE_DEPTH entries, then the front register, and only then req_full rises.
// Reset is synchronous, active high: all stages and the queue empty, the palette
// returns to rainbow. There is no clearing pass.
`default_nettype none

module palette_hsv_to_rgb #(
   parameter int QUEUE_DEPTH = phr_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire phr_pkg::req_type    req_data,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output phr_pkg::rsp_type         rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_data
);

   logic                q_push;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   phr_pkg::shade_type  q_in_data;
   phr_pkg::shade_type  q_out_data;

   assign csr_ready = 1'b1;

   phr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_data    (q_in_data)
   );

   phr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_in_data),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_out_data)
   );

   phr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_out_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result visible right after reset");

   a_queue_consistent: assert property (@(posedge clock) disable iff (reset)
      !(q_full && !q_valid))
      else $error("queue full and empty at once");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      q_push |=> q_valid)
      else $error("pushed request missing from queue");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("shading stage popped an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/phr_front.sv
`default_nettype none

module phr_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [2:0]          csr_data,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire phr_pkg::req_type    req_data,
   output logic                     q_push,
   input  wire logic                q_full,
   output phr_pkg::shade_type       q_data
);

   logic [2:0]          palette_ff;
   logic [2:0]          palette_in;
   logic                fr_valid_ff;
   logic                fr_valid_in;
   phr_pkg::shade_type  fr_data_ff;
   phr_pkg::shade_type  fr_data_in;

   logic                accept;
   logic [2:0]          pal;
   logic                wide;
   logic [2:0]          sector;
   logic [2:0]          next_idx;
   logic [5:0]          offset;
   phr_pkg::color_type  base_color;
   phr_pkg::color_type  next_color;

   // base + trunc((next - base) / span) * offset, clamped to 0..255
   function automatic logic [7:0] lerp(input logic [7:0] base, input logic [7:0] nxt,
                                       input logic wide_span, input logic [5:0] ofs);
      logic       neg;
      logic [7:0] mag;
      logic [2:0] slope;
      logic [8:0] prod;
      logic [9:0] up;
      logic [8:0] down;
      logic [7:0] res;
      neg   = nxt < base;
      mag   = neg ? (base - nxt) : (nxt - base);
      slope = wide_span ? mag[7:5] : {1'b0, mag[7:6]};
      prod  = 9'(slope) * 9'(ofs);
      up    = 10'(base) + 10'(prod);
      down  = 9'(base) - prod;
      if (neg) begin
         res = (prod > 9'(base)) ? 8'd0 : down[7:0];
      end else begin
         res = (up > 10'd255) ? 8'd255 : up[7:0];
      end
      return res;
   endfunction

   always_comb begin
      palette_in = csr_valid ? csr_data : palette_ff;
      pal        = (palette_ff > phr_pkg::PAL_FLAG) ? phr_pkg::PAL_RAINBOW : palette_ff;
      wide       = (pal == phr_pkg::PAL_RAINBOW) || (pal == phr_pkg::PAL_REORDERED);
      if (wide) begin
         sector   = req_data.hue[7:5];
         offset   = {1'b0, req_data.hue[4:0]};
         next_idx = sector + 3'd1;
      end else begin
         sector   = {1'b0, req_data.hue[7:6]};
         offset   = req_data.hue[5:0];
         next_idx = {1'b0, sector[1:0] + 2'd1};
      end
      base_color = phr_pkg::PAL_ROM[pal][sector];
      next_color = phr_pkg::PAL_ROM[pal][next_idx];

      fr_data_in.red        = lerp(base_color[23:16], next_color[23:16], wide, offset);
      fr_data_in.green      = lerp(base_color[15:8],  next_color[15:8],  wide, offset);
      fr_data_in.blue       = lerp(base_color[7:0],   next_color[7:0],   wide, offset);
      fr_data_in.saturation = req_data.saturation;
      fr_data_in.brightness = req_data.brightness;

      req_full = fr_valid_ff && q_full;
      accept   = req_push && !req_full;
      q_push   = fr_valid_ff && !q_full;
      q_data   = fr_data_ff;

      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (q_push) begin
         fr_valid_in = 1'b0;
      end else begin
         fr_valid_in = fr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff  <= phr_pkg::PAL_RAINBOW;
         fr_valid_ff <= 1'b0;
      end else begin
         palette_ff  <= palette_in;
         fr_valid_ff <= fr_valid_in;
      end
      if (accept) begin
         fr_data_ff <= fr_data_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/phr_queue.sv
`default_nettype none

module phr_queue #(
   parameter int DEPTH = phr_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire phr_pkg::shade_type  push_data,
   output logic                     valid,
   input  wire logic                pop,
   output phr_pkg::shade_type       pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   phr_pkg::shade_type  store_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      full     = count_ff == CNT_W'(DEPTH);
      valid    = count_ff != '0;
      do_push  = push && !full;
      do_pop   = pop && valid;
      pop_data = store_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/phr_back.sv
`default_nettype none

module phr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_pop,
   input  wire phr_pkg::shade_type  q_data,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output phr_pkg::rsp_type         rsp_data
);

   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;
   logic [2:0][15:0]       s1_prod_ff;
   logic [2:0][15:0]       s1_prod_in;
   logic [7:0]             s1_bright_ff;
   logic [2:0][15:0]       s2_prod_ff;
   logic [2:0][15:0]       s2_prod_in;
   logic [2:0][7:0]        s3_color_ff;
   logic [2:0][7:0]        s3_color_in;
   logic [2:0][7:0]        color;
   logic [2:0][7:0]        faded;
   logic                   ready1, ready2, ready3;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   always_comb begin
      color = {q_data.red, q_data.green, q_data.blue};

      ready3 = !v3_ff || rsp_pop;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;
      q_pop  = q_valid && ready1;

      for (int i = 0; i < 3; i++) begin
         s1_prod_in[i]  = 16'(8'd255 - color[i]) * 16'(q_data.saturation);
         faded[i]       = 8'd255 - div255(s1_prod_ff[i]);
         s2_prod_in[i]  = 16'(faded[i]) * 16'(s1_bright_ff);
         s3_color_in[i] = div255(s2_prod_ff[i]);
      end

      v1_in = ready1 ? q_valid : v1_ff;
      v2_in = ready2 ? v1_ff : v2_ff;
      v3_in = ready3 ? v2_ff : v3_ff;

      rsp_empty      = !v3_ff;
      rsp_data.red   = s3_color_ff[2];
      rsp_data.green = s3_color_ff[1];
      rsp_data.blue  = s3_color_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (ready1) begin
         s1_prod_ff   <= s1_prod_in;
         s1_bright_ff <= q_data.brightness;
      end
      if (ready2) begin
         s2_prod_ff <= s2_prod_in;
      end
      if (ready3) begin
         s3_color_ff <= s3_color_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import phr_pkg::*;

   // palette codes beyond the ROM fall back to rainbow
   localparam logic [2:0] PAL_UNUSED_6 = 3'd6;
   localparam logic [2:0] PAL_UNUSED_7 = 3'd7;

   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 210;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;

   localparam int PALETTE_COLORS [6] = '{8, 8, 4, 4, 4, 4};

   localparam logic [23:0] PALETTE_TABLE [6][8] = '{
      '{24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h00FF00,
        24'h00FFFF, 24'h0000FF, 24'h8000FF, 24'hFF0000},
      '{24'h00FFFF, 24'h8000FF, 24'h0000FF, 24'hFFFF00,
        24'h00FF00, 24'hFF8000, 24'hFF0000, 24'h00FFFF},
      '{24'hFFFF00, 24'hFF8000, 24'hFF0000, 24'hFFFF00,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'h00FFFF, 24'h0080FF, 24'h0000FF, 24'h00FFFF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'h80FF00, 24'hBFFF00, 24'hFFFF00, 24'h80FF00,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000}
   };

   localparam logic [2:0] PHASE_PALETTES [PHASE_COUNT] = '{
      PAL_FLAG, PAL_REORDERED, PAL_UNUSED_6, PAL_SUNNY,
      PAL_UNUSED_7, PAL_COLD, PAL_GREEN, PAL_RAINBOW
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_data = PAL_RAINBOW;

   req_type    pending_requests [$];
   rsp_type    rgb_expected [$];
   logic [2:0] active_palette = PAL_RAINBOW;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   // sender pacing
   int         burst_left = 0;
   int         gap_left = 0;
   bit         sender_steady = 1'b0;

   // receiver pacing
   logic [7:0] stall_pattern = 8'hFF;
   int         pattern_age = 0;
   int         hold_left = 0;
   bit         hold_request = 1'b0;

   palette_hsv_to_rgb u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic rsp_type palette_shade(req_type item, logic [2:0] code);
      int      pal, colors, span, sector, offset, next_idx;
      int      base, target, slope, level;
      int      levels [3];
      logic [23:0] base_rgb, next_rgb;
      rsp_type rgb;
      pal = (int'(code) < PAL_COUNT) ? int'(code) : int'(PAL_RAINBOW);
      colors = PALETTE_COLORS[pal];
      span = 256 / colors;
      sector = int'(item.hue) / span;
      offset = int'(item.hue) % span;
      next_idx = (sector + 1 >= colors) ? 0 : sector + 1;
      base_rgb = PALETTE_TABLE[pal][sector];
      next_rgb = PALETTE_TABLE[pal][next_idx];
      for (int ch = 0; ch < 3; ch++) begin
         base = int'(base_rgb[23 - 8 * ch -: 8]);
         target = int'(next_rgb[23 - 8 * ch -: 8]);
         // slope truncates toward zero before scaling by the offset
         slope = (target - base) / span;
         level = base + slope * offset;
         if (level < 0) begin
            level = 0;
         end else if (level > 255) begin
            level = 255;
         end
         level = 255 - ((255 - level) * int'(item.saturation)) / 255;
         levels[ch] = (level * int'(item.brightness)) / 255;
      end
      rgb.red = levels[0][7:0];
      rgb.green = levels[1][7:0];
      rgb.blue = levels[2][7:0];
      return rgb;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_rgb(input rsp_type got);
      rsp_type want;
      if (rgb_expected.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
      end else begin
         want = rgb_expected.pop_front();
         if (got.red !== want.red) begin
            report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
         end
         if (got.green !== want.green) begin
            report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
         end
         if (got.blue !== want.blue) begin
            report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
         end
      end
   endtask

   // sender: bursts of requests separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            rgb_expected.push_back(palette_shade(req_data, active_palette));
         end
         if (req_push && req_full) begin
            // hold the offered request until taken
         end else if (gap_left > 0 && !sender_steady) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_push <= 1'b1;
            req_data <= pending_requests.pop_front();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: checks results, stalls on a rotating pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_rgb(rsp_data);
         end
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 8'hFF;
               1: stall_pattern = 8'hFF ^ (8'h1 << $urandom_range(0, 7));
               default: stall_pattern = 8'($urandom_range(1, 255));
            endcase
            pattern_age = 31;
         end else begin
            pattern_age--;
         end
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= stall_pattern[pattern_age[2:0]];
         end
      end
   end

   function automatic logic [7:0] pick_hue();
      logic [7:0] edge_hue;
      if ($urandom_range(0, 3) == 0) begin
         // land near a sector boundary
         edge_hue = 8'($urandom_range(0, 7) * 32);
         return edge_hue + 8'($urandom_range(0, 2)) - 8'd1;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 3));
         3: return 8'($urandom_range(252, 254));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_request(input logic [7:0] hue, input logic [7:0] sat,
                                input logic [7:0] val);
      req_type item;
      item.hue = hue;
      item.saturation = sat;
      item.brightness = val;
      pending_requests.push_back(item);
   endtask

   // sample at the falling edge so the sender's updates have settled
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_push || rgb_expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_palette(input logic [2:0] code);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock); while (!csr_ready);
      active_palette = code;
      csr_valid <= 1'b0;
   endtask

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [7:0] edge_hues [12];
      edge_hues = '{8'd0, 8'd31, 8'd32, 8'd63, 8'd64, 8'd127,
                    8'd128, 8'd191, 8'd192, 8'd223, 8'd224, 8'd255};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset palette: sector edges at full color, then the shading extremes
      sender_steady = 1'b1;
      foreach (edge_hues[i]) begin
         queue_request(edge_hues[i], 8'd255, 8'd255);
      end
      queue_request(8'd100, 8'd0, 8'd255);
      queue_request(8'd100, 8'd255, 8'd0);
      queue_request(8'd200, 8'd128, 8'd128);
      queue_request(8'd50, 8'd1, 8'd254);
      queue_request(8'd170, 8'd254, 8'd1);
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_palette(PHASE_PALETTES[phase]);
         sender_steady = (phase % 3 == 1);
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            queue_request(pick_hue(), pick_level(), pick_level());
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/phr_pkg.sv
rtl/phr_front.sv
rtl/phr_queue.sv
rtl/phr_back.sv
rtl/palette_hsv_to_rgb.sv
tb/tb.sv
